>>> rtl/core/leg_gait_phase_sequencer_macros.svh
// Assertion macros shared by the leg gait phase sequencer RTL.
`ifndef LEG_GAIT_PHASE_SEQUENCER_MACROS_SVH
`define LEG_GAIT_PHASE_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define LGPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lgps: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define LGPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lgps: next-cycle check failed");

`endif

>>> rtl/core/lgps_pkg.sv
// Package for the leg gait phase sequencer: types, register map and constants.
package lgps_pkg;

    // Countdown width; each configured field is cut to this many bits
    localparam int unsigned COUNT_WIDTH  = 16;
    localparam int unsigned NUM_LEGS     = 4;
    localparam int unsigned NUM_PHASES   = 6;
    localparam int unsigned FIELD_W      = 16;
    localparam int unsigned PHASE_CODE_W = 3;
    localparam int unsigned START_PH_W   = NUM_LEGS * PHASE_CODE_W;
    localparam int unsigned VALVE_W      = 8;

    // APB register file
    localparam int unsigned APB_DATA_W   = 64;
    localparam int unsigned APB_ADDR_W   = 6;
    localparam logic [START_PH_W-1:0] START_PHASES_RST = START_PH_W'(3510);

    // ceil(d/25) = floor((d+24)/25), done as multiply by reciprocal and shift
    localparam int unsigned STANCE_DIV   = 25;
    localparam int unsigned RECIP_SHIFT  = 21;
    localparam int unsigned RECIP_W      = 17;
    localparam logic [RECIP_W-1:0] RECIP_MUL =
        RECIP_W'((2**RECIP_SHIFT + STANCE_DIV - 1) / STANCE_DIV);
    localparam int unsigned DIV_IN_W     = COUNT_WIDTH + 1;
    localparam int unsigned PROD_W       = DIV_IN_W + RECIP_W;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    typedef enum logic [PHASE_CODE_W-1:0] {
        PH_DETACH     = 3'd0,
        PH_SWING_UP   = 3'd1,
        PH_SWING_DOWN = 3'd2,
        PH_ATTACH     = 3'd3,
        PH_RECOVER    = 3'd4,
        PH_STANCE     = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        REG_DETACH_COUNTS     = 3'd0,
        REG_SWING_UP_COUNTS   = 3'd1,
        REG_SWING_DOWN_COUNTS = 3'd2,
        REG_ATTACH_COUNTS     = 3'd3,
        REG_RECOVER_COUNTS    = 3'd4,
        REG_STANCE_COUNTS     = 3'd5,
        REG_START_PHASES      = 3'd6,
        REG_START_COUNTS      = 3'd7
    } t_reg_idx;

    // Negative valve bit of each leg's slot; the positive bit sits just above
    localparam logic [2:0] VALVE_NEG_POS [NUM_LEGS] = '{3'd0, 3'd6, 3'd2, 3'd4};

    // Configuration as seen by the datapath
    typedef struct packed {
        t_count [NUM_LEGS-1:0][NUM_PHASES-1:0]   dur;
        logic   [NUM_LEGS-1:0][PHASE_CODE_W-1:0] start_code;
        t_count [NUM_LEGS-1:0]                   start_count;
        t_count [NUM_LEGS-1:0]                   stance_limit;
    } t_cfg;

    // Per-leg events and valve requests
    typedef struct packed {
        logic sw_start;
        logic sw_end;
        logic set_neg;
        logic set_pos;
    } t_leg_flags;

    // Registered result word
    typedef struct packed {
        t_phase [NUM_LEGS-1:0] phase;
        t_count [NUM_LEGS-1:0] count;
        logic   [VALVE_W-1:0]  valve;
        logic                  sw_start;
        logic                  sw_end;
    } t_result;

endpackage

>>> rtl/core/lgps_in_if.sv
// Command channel: one restart-or-tick word per handshake.
interface lgps_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

>>> rtl/core/lgps_out_if.sv
// Result channel: leg phases, countdowns, valve word and swing pulses.
interface lgps_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  leg0_phase;
    logic [2:0]  leg1_phase;
    logic [2:0]  leg2_phase;
    logic [2:0]  leg3_phase;
    logic [15:0] leg0_remaining;
    logic [15:0] leg1_remaining;
    logic [15:0] leg2_remaining;
    logic [15:0] leg3_remaining;
    logic [7:0]  valve_word;
    logic        swing_start;
    logic        swing_end;

    modport source (
        output valid, input ready,
        output leg0_phase, output leg1_phase, output leg2_phase, output leg3_phase,
        output leg0_remaining, output leg1_remaining,
        output leg2_remaining, output leg3_remaining,
        output valve_word, output swing_start, output swing_end
    );
    modport sink (
        input valid, output ready,
        input leg0_phase, input leg1_phase, input leg2_phase, input leg3_phase,
        input leg0_remaining, input leg1_remaining,
        input leg2_remaining, input leg3_remaining,
        input valve_word, input swing_start, input swing_end
    );
endinterface

>>> rtl/core/lgps_apb_regs.sv
// APB register file with per-leg field extraction and stance valve limits.
module lgps_apb_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lgps_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lgps_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lgps_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output lgps_pkg::t_cfg                      o_cfg
);

    logic [lgps_pkg::APB_DATA_W-1:0] r_dur [lgps_pkg::NUM_PHASES];
    logic [lgps_pkg::START_PH_W-1:0] r_start_phases;
    logic [lgps_pkg::APB_DATA_W-1:0] r_start_counts;
    lgps_pkg::t_count                r_stance_limit [lgps_pkg::NUM_LEGS];

    lgps_pkg::t_reg_idx              w_idx;
    logic                            w_wr;

    assign pready = 1'b1;
    assign w_idx  = lgps_pkg::t_reg_idx'(paddr[lgps_pkg::APB_ADDR_W-1:3]);
    assign w_wr   = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < lgps_pkg::NUM_PHASES; p++) begin
                r_dur[p] <= '0;
            end
            r_start_phases <= lgps_pkg::START_PHASES_RST;
            r_start_counts <= '0;
        end else if (w_wr) begin
            case (w_idx)
                lgps_pkg::REG_DETACH_COUNTS:     r_dur[0] <= pwdata;
                lgps_pkg::REG_SWING_UP_COUNTS:   r_dur[1] <= pwdata;
                lgps_pkg::REG_SWING_DOWN_COUNTS: r_dur[2] <= pwdata;
                lgps_pkg::REG_ATTACH_COUNTS:     r_dur[3] <= pwdata;
                lgps_pkg::REG_RECOVER_COUNTS:    r_dur[4] <= pwdata;
                lgps_pkg::REG_STANCE_COUNTS:     r_dur[5] <= pwdata;
                lgps_pkg::REG_START_PHASES: begin
                    r_start_phases <= pwdata[lgps_pkg::START_PH_W-1:0];
                end
                lgps_pkg::REG_START_COUNTS:      r_start_counts <= pwdata;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            lgps_pkg::REG_DETACH_COUNTS:     prdata = r_dur[0];
            lgps_pkg::REG_SWING_UP_COUNTS:   prdata = r_dur[1];
            lgps_pkg::REG_SWING_DOWN_COUNTS: prdata = r_dur[2];
            lgps_pkg::REG_ATTACH_COUNTS:     prdata = r_dur[3];
            lgps_pkg::REG_RECOVER_COUNTS:    prdata = r_dur[4];
            lgps_pkg::REG_STANCE_COUNTS:     prdata = r_dur[5];
            lgps_pkg::REG_START_PHASES: begin
                prdata = lgps_pkg::APB_DATA_W'(r_start_phases);
            end
            lgps_pkg::REG_START_COUNTS:      prdata = r_start_counts;
            default:                         prdata = '0;
        endcase
    end

    // stance valve limit ceil(d/25), registered behind the stance count register
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < lgps_pkg::NUM_LEGS; l++) begin
            r_stance_limit[l] <= lgps_pkg::COUNT_WIDTH'(
                ((lgps_pkg::PROD_W'(lgps_pkg::DIV_IN_W'(
                    r_dur[5][l*lgps_pkg::FIELD_W +: lgps_pkg::COUNT_WIDTH])
                    + lgps_pkg::DIV_IN_W'(lgps_pkg::STANCE_DIV - 1)))
                 * lgps_pkg::PROD_W'(lgps_pkg::RECIP_MUL)) >> lgps_pkg::RECIP_SHIFT);
        end
    end

    // per-leg fields
    always_comb begin
        for (int l = 0; l < lgps_pkg::NUM_LEGS; l++) begin
            for (int p = 0; p < lgps_pkg::NUM_PHASES; p++) begin
                o_cfg.dur[l][p] = r_dur[p][l*lgps_pkg::FIELD_W +: lgps_pkg::COUNT_WIDTH];
            end
            o_cfg.start_code[l] =
                r_start_phases[l*lgps_pkg::PHASE_CODE_W +: lgps_pkg::PHASE_CODE_W];
            o_cfg.start_count[l] =
                r_start_counts[l*lgps_pkg::FIELD_W +: lgps_pkg::COUNT_WIDTH];
            o_cfg.stance_limit[l] = r_stance_limit[l];
        end
    end

endmodule

>>> rtl/core/lgps_leg_step.sv
// Next phase, countdown, swing events and valve requests of one leg.
module lgps_leg_step (
    input  logic                                          i_restart,
    input  lgps_pkg::t_phase                              i_phase,
    input  lgps_pkg::t_count                              i_count,
    input  logic [lgps_pkg::PHASE_CODE_W-1:0]             i_start_code,
    input  lgps_pkg::t_count                              i_start_count,
    input  lgps_pkg::t_count [lgps_pkg::NUM_PHASES-1:0]   i_dur,
    input  lgps_pkg::t_count                              i_stance_limit,
    output lgps_pkg::t_phase                              o_phase,
    output lgps_pkg::t_count                              o_count,
    output lgps_pkg::t_leg_flags                          o_flags
);

    lgps_pkg::t_phase w_next_ph;
    lgps_pkg::t_count w_decr;

    // saturating countdown
    assign w_decr = (i_count != '0) ? i_count - lgps_pkg::COUNT_WIDTH'(1) : '0;

    // gait order: detach, up, down, attach, recover, stance, detach
    always_comb begin
        case (i_phase)
            lgps_pkg::PH_DETACH:     w_next_ph = lgps_pkg::PH_SWING_UP;
            lgps_pkg::PH_SWING_UP:   w_next_ph = lgps_pkg::PH_SWING_DOWN;
            lgps_pkg::PH_SWING_DOWN: w_next_ph = lgps_pkg::PH_ATTACH;
            lgps_pkg::PH_ATTACH:     w_next_ph = lgps_pkg::PH_RECOVER;
            lgps_pkg::PH_RECOVER:    w_next_ph = lgps_pkg::PH_STANCE;
            default:                 w_next_ph = lgps_pkg::PH_DETACH;
        endcase
    end

    always_comb begin
        o_phase = i_phase;
        o_count = w_decr;
        o_flags = '0;
        if (i_restart) begin
            // codes past stance load as stance
            if (i_start_code >= lgps_pkg::PHASE_CODE_W'(lgps_pkg::NUM_PHASES)) begin
                o_phase = lgps_pkg::PH_STANCE;
            end else begin
                o_phase = lgps_pkg::t_phase'(i_start_code);
            end
            o_count = i_start_count;
        end else begin
            if (w_decr == '0) begin
                o_phase          = w_next_ph;
                o_count          = i_dur[w_next_ph];
                o_flags.sw_end   = (i_phase == lgps_pkg::PH_ATTACH);
                o_flags.sw_start = (i_phase == lgps_pkg::PH_STANCE);
            end
            // valve requests from the updated phase and count
            o_flags.set_neg = (o_phase == lgps_pkg::PH_SWING_DOWN);
            o_flags.set_pos = (o_phase == lgps_pkg::PH_STANCE) && (o_count <= i_stance_limit);
        end
    end

endmodule

>>> rtl/core/leg_gait_phase_sequencer.sv
// Leg gait phase sequencer: input stage, four leg step units, result register.
// A word waits in the input stage, then enters the result register once it is free.
// Throughput: one word per cycle unless the output stalls; single update stage.
// Config writes are registered; the stance limit adds one more register.
// Reset (synchronous, active low): legs in stance, countdowns and valve word zero,
// registers at reset values, both pipeline stages empty.
`include "leg_gait_phase_sequencer_macros.svh"

module leg_gait_phase_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    lgps_in_if.sink                           i_cmd,
    lgps_out_if.source                        o_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lgps_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lgps_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lgps_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    lgps_pkg::t_cfg                                w_cfg;

    // input stage
    logic                                          r_in_valid;
    logic                                          r_in_restart;
    logic                                          w_advance;

    // leg state
    lgps_pkg::t_phase [lgps_pkg::NUM_LEGS-1:0]     r_phase;
    lgps_pkg::t_count [lgps_pkg::NUM_LEGS-1:0]     r_count;
    logic [lgps_pkg::VALVE_W-1:0]                  r_valve;
    lgps_pkg::t_phase [lgps_pkg::NUM_LEGS-1:0]     n_phase;
    lgps_pkg::t_count [lgps_pkg::NUM_LEGS-1:0]     n_count;
    logic [lgps_pkg::VALVE_W-1:0]                  n_valve;
    lgps_pkg::t_leg_flags [lgps_pkg::NUM_LEGS-1:0] w_flags;

    // result stage
    logic                                          r_out_valid;
    logic                                          r_out_restart;
    lgps_pkg::t_result                             r_out;
    logic                                          w_leg0_down;

    lgps_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // the update stage moves when the result register is free or being drained
    assign w_advance   = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_restart <= i_cmd.restart;
        end
    end

    // per-leg step units
    for (genvar l = 0; l < lgps_pkg::NUM_LEGS; l++) begin : g_leg
        lgps_leg_step u_step (
            .i_restart      (r_in_restart),
            .i_phase        (r_phase[l]),
            .i_count        (r_count[l]),
            .i_start_code   (w_cfg.start_code[l]),
            .i_start_count  (w_cfg.start_count[l]),
            .i_dur          (w_cfg.dur[l]),
            .i_stance_limit (w_cfg.stance_limit[l]),
            .o_phase        (n_phase[l]),
            .o_count        (n_count[l]),
            .o_flags        (w_flags[l])
        );
    end

    // valve word: each leg owns one slot, so leg order does not matter
    always_comb begin
        n_valve = r_valve;
        for (int l = 0; l < lgps_pkg::NUM_LEGS; l++) begin
            if (w_flags[l].set_neg) begin
                n_valve[lgps_pkg::VALVE_NEG_POS[l]]                    = 1'b1;
                n_valve[{lgps_pkg::VALVE_NEG_POS[l][2:1], 1'b1}]       = 1'b0;
            end else if (w_flags[l].set_pos) begin
                n_valve[lgps_pkg::VALVE_NEG_POS[l]]                    = 1'b0;
                n_valve[{lgps_pkg::VALVE_NEG_POS[l][2:1], 1'b1}]       = 1'b1;
            end
        end
    end

    // state update and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < lgps_pkg::NUM_LEGS; l++) begin
                r_phase[l] <= lgps_pkg::PH_STANCE;
                r_count[l] <= '0;
            end
            r_valve     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_phase     <= n_phase;
                r_count     <= n_count;
                r_valve     <= n_valve;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_advance) begin
            r_out.phase    <= n_phase;
            r_out.count    <= n_count;
            r_out.valve    <= n_valve;
            r_out.sw_start <= w_flags[0].sw_start || w_flags[1].sw_start
                           || w_flags[2].sw_start || w_flags[3].sw_start;
            r_out.sw_end   <= w_flags[0].sw_end || w_flags[1].sw_end
                           || w_flags[2].sw_end || w_flags[3].sw_end;
            r_out_restart  <= r_in_restart;
        end
    end

    // result port
    assign o_res.valid          = r_out_valid;
    assign o_res.leg0_phase     = r_out.phase[0];
    assign o_res.leg1_phase     = r_out.phase[1];
    assign o_res.leg2_phase     = r_out.phase[2];
    assign o_res.leg3_phase     = r_out.phase[3];
    assign o_res.leg0_remaining = lgps_pkg::FIELD_W'(r_out.count[0]);
    assign o_res.leg1_remaining = lgps_pkg::FIELD_W'(r_out.count[1]);
    assign o_res.leg2_remaining = lgps_pkg::FIELD_W'(r_out.count[2]);
    assign o_res.leg3_remaining = lgps_pkg::FIELD_W'(r_out.count[3]);
    assign o_res.valve_word     = r_out.valve;
    assign o_res.swing_start    = r_out.sw_start;
    assign o_res.swing_end      = r_out.sw_end;

    assign w_leg0_down = o_res.valid && !r_out_restart
                      && (r_out.phase[0] == lgps_pkg::PH_SWING_DOWN);

    // checks
    `LGPS_ASSERT_SAME(a_restart_no_swing, i_clk, i_rst_n, o_res.valid && r_out_restart, !o_res.swing_start && !o_res.swing_end)
    `LGPS_ASSERT_NEXT(a_restart_keeps_valve, i_clk, i_rst_n, w_advance && r_in_restart, $stable(r_valve))
    `LGPS_ASSERT_NEXT(a_state_holds_on_stall, i_clk, i_rst_n, !w_advance, $stable(r_phase) && $stable(r_count))
    `LGPS_ASSERT_SAME(a_leg0_down_neg_valve, i_clk, i_rst_n, w_leg0_down, o_res.valve_word[0] && !o_res.valve_word[1])

endmodule
